>>> hw/rtl/sorted_table_search_defines.svh
// Assertion macros shared by the sorted table search RTL.
`ifndef SORTED_TABLE_SEARCH_DEFINES_SVH
`define SORTED_TABLE_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset.
`define STS_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define STS_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/sts_pkg.sv
// Types and constants shared by the sorted table search controller and datapath.
package sts_pkg;

	// Fixed field widths
	localparam int INDEX_W = 10;
	localparam int RANGE_W = 11;
	localparam int RANK_W  = 10;
	localparam int PADDR_W = 2;

	// Command codes
	localparam logic CMD_LOAD   = 1'b0;
	localparam logic CMD_SEARCH = 1'b1;

	// Search modes; the unused code behaves as three-way
	localparam logic [1:0] MODE_THREE_WAY = 2'd0;
	localparam logic [1:0] MODE_FIBONACCI = 2'd1;
	localparam logic [1:0] MODE_TWO_WAY   = 2'd2;

	// Register byte addresses
	localparam logic [PADDR_W-1:0] ADDR_SEARCH_MODE = 2'd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIB_GROW,
		ST_FIB_SHRINK,
		ST_PROBE,
		ST_COMPARE,
		ST_LAST_READ,
		ST_LAST_CMP
	} sts_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load_we;
		logic search_start;
		logic fib_grow;
		logic fib_shrink;
		logic probe;
		logic probe_fib;
		logic upd_three;
		logic upd_two;
		logic last_rd;
		logic finish;
		logic finish_hit;
		logic rank_lo;
	} sts_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;
		logic in_span_gt1;
		logic cur_lt_n;
		logic n_lt_cur;
		logic eq;
		logic nxt_nonempty;
		logic nxt_span_gt1;
	} sts_status_t;

endpackage

>>> hw/rtl/sts_datapath.sv
// Datapath: table memory, range and Fibonacci registers, key compare and result registers.
`include "sorted_table_search_defines.svh"

module sts_datapath import sts_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  sts_cmd_t                      cmd,
	input  logic [INDEX_W-1:0]            entry_index,
	input  logic signed [VALUE_WIDTH-1:0] item_value,
	input  logic [RANGE_W-1:0]            range_low,
	input  logic [RANGE_W-1:0]            range_high,
	output sts_status_t                   sts,
	output logic                          done,
	output logic                          found,
	output logic [RANK_W-1:0]             match_rank
);

	localparam int RW = $clog2(TABLE_DEPTH + 1);
	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int FW = RW + 1;
	localparam int CW = (RW > RANGE_W) ? RW : RANGE_W;
	localparam int IW = (RW > INDEX_W) ? RW : INDEX_W;

	logic signed [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];
	logic signed [VALUE_WIDTH-1:0] key_q;
	logic signed [VALUE_WIDTH-1:0] rdata_q;
	logic [RW-1:0]                 lo_q;
	logic [RW-1:0]                 hi_q;
	logic [RW-1:0]                 mid_q;
	logic [FW-1:0]                 cur_q;
	logic [FW-1:0]                 prev_q;
	logic                          done_q;
	logic                          found_q;
	logic [RANK_W-1:0]             rank_q;

	logic [IW-1:0] idx_ext;
	logic          idx_ok;
	logic [CW-1:0] lo_in;
	logic [CW-1:0] hi_raw;
	logic [CW-1:0] hi_sat;
	logic [CW-1:0] in_span;
	logic [RW-1:0] span;
	logic [RW:0]   sum_lh;
	logic [RW-1:0] mid_bin;
	logic [RW-1:0] mid_fib;
	logic [RW-1:0] probe_mid;
	logic [RW-1:0] mid_plus1;
	logic [AW-1:0] raddr;
	logic          lt;
	logic          eq;
	logic [RW-1:0] nxt_lo3;
	logic [RW-1:0] nxt_hi3;
	logic [RW-1:0] nxt_lo2;
	logic [RW-1:0] nxt_hi2;
	logic [RW-1:0] rank_sel;

	// Check the load position and saturate the range end
	always_comb begin
		idx_ext = IW'(entry_index);
		idx_ok  = idx_ext < IW'(TABLE_DEPTH);
		lo_in   = CW'(range_low);
		hi_raw  = CW'(range_high);
		hi_sat  = (hi_raw > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : hi_raw;
		in_span = hi_sat - lo_in;
	end

	// Probe positions
	always_comb begin
		span      = hi_q - lo_q;
		sum_lh    = {1'b0, lo_q} + {1'b0, hi_q};
		mid_bin   = sum_lh[RW:1];
		mid_fib   = RW'(FW'(lo_q) + cur_q - FW'(1));
		probe_mid = cmd.probe_fib ? mid_fib : mid_bin;
		mid_plus1 = RW'({1'b0, mid_q} + {{RW{1'b0}}, 1'b1});
		raddr     = cmd.last_rd ? lo_q[AW-1:0] : probe_mid[AW-1:0];
	end

	// Compare the key with the probed entry and form the narrowed ranges
	always_comb begin
		lt      = key_q < rdata_q;
		eq      = key_q == rdata_q;
		nxt_lo3 = lt ? lo_q : mid_plus1;
		nxt_hi3 = lt ? mid_q : hi_q;
		nxt_lo2 = lt ? lo_q : mid_q;
		nxt_hi2 = lt ? mid_q : hi_q;
		rank_sel = cmd.rank_lo ? lo_q : mid_q;
	end

	// Report status to the controller
	always_comb begin
		sts.empty        = lo_in >= hi_sat;
		sts.in_span_gt1  = in_span > CW'(1);
		sts.cur_lt_n     = cur_q < FW'(span);
		sts.n_lt_cur     = FW'(span) < cur_q;
		sts.eq           = eq;
		sts.nxt_nonempty = nxt_lo3 < nxt_hi3;
		sts.nxt_span_gt1 = RW'(nxt_hi2 - nxt_lo2) > RW'(1);
	end

	// Table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load_we && idx_ok) begin
			mem[idx_ext[AW-1:0]] <= item_value;
		end
		if (cmd.probe || cmd.last_rd) begin
			rdata_q <= mem[raddr];
		end
	end

	// Range, probe and Fibonacci registers
	always_ff @(posedge clk) begin
		if (cmd.search_start) begin
			key_q  <= item_value;
			lo_q   <= RW'(lo_in);
			hi_q   <= RW'(hi_sat);
			prev_q <= FW'(1);
			cur_q  <= '0;
		end else begin
			if (cmd.fib_grow) begin
				cur_q  <= cur_q + prev_q;
				prev_q <= cur_q;
			end else if (cmd.fib_shrink) begin
				cur_q  <= prev_q;
				prev_q <= cur_q - prev_q;
			end
			if (cmd.upd_three) begin
				lo_q <= nxt_lo3;
				hi_q <= nxt_hi3;
			end else if (cmd.upd_two) begin
				lo_q <= nxt_lo2;
				hi_q <= nxt_hi2;
			end
		end
		if (cmd.probe) begin
			mid_q <= probe_mid;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			found_q <= cmd.finish_hit;
			rank_q  <= cmd.finish_hit ? RANK_W'(rank_sel) : '0;
		end
	end

	// Result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	assign done       = done_q;
	assign found      = found_q;
	assign match_rank = rank_q;

	`STS_ASSERT_IMP(a_probe_in_range, cmd.probe, (probe_mid >= lo_q) && (probe_mid < hi_q), "probe outside the live range")
	`STS_ASSERT_IMP(a_miss_rank_zero, done_q && !found_q, rank_q == '0, "miss with nonzero rank")

endmodule

>>> hw/rtl/sts_ctrl.sv
// Controller: search sequencer state machine for the three probe schemes.
`include "sorted_table_search_defines.svh"

module sts_ctrl import sts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        command,
	input  logic [1:0]  search_mode,
	input  sts_status_t sts,
	output sts_cmd_t    cmd,
	output logic        busy
);

	sts_state_t state_q;
	sts_state_t state_d;
	logic       mode_fib;
	logic       mode_two;
	logic       take_load;
	logic       take_search;

	// Decode mode and incoming transaction
	always_comb begin
		mode_fib    = search_mode == MODE_FIBONACCI;
		mode_two    = search_mode == MODE_TWO_WAY;
		take_load   = (state_q == ST_IDLE) && start && (command == CMD_LOAD);
		take_search = (state_q == ST_IDLE) && start && (command == CMD_SEARCH);
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (take_search && !sts.empty) begin
					if (mode_fib) begin
						state_d = ST_FIB_GROW;
					end else if (mode_two) begin
						state_d = sts.in_span_gt1 ? ST_PROBE : ST_LAST_READ;
					end else begin
						state_d = ST_PROBE;
					end
				end
			end
			ST_FIB_GROW: begin
				if (!sts.cur_lt_n) begin
					state_d = ST_FIB_SHRINK;
				end
			end
			ST_FIB_SHRINK: begin
				if (!sts.n_lt_cur) begin
					state_d = ST_PROBE;
				end
			end
			ST_PROBE: begin
				state_d = ST_COMPARE;
			end
			ST_COMPARE: begin
				if (mode_two) begin
					state_d = sts.nxt_span_gt1 ? ST_PROBE : ST_LAST_READ;
				end else if (sts.eq || !sts.nxt_nonempty) begin
					state_d = ST_IDLE;
				end else begin
					state_d = mode_fib ? ST_FIB_SHRINK : ST_PROBE;
				end
			end
			ST_LAST_READ: begin
				state_d = ST_LAST_CMP;
			end
			ST_LAST_CMP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath commands
	always_comb begin
		cmd              = '0;
		cmd.load_we      = take_load;
		cmd.search_start = take_search;
		cmd.probe_fib    = mode_fib;
		case (state_q)
			ST_IDLE: begin
				cmd.finish = take_search && sts.empty;
			end
			ST_FIB_GROW: begin
				cmd.fib_grow = sts.cur_lt_n;
			end
			ST_FIB_SHRINK: begin
				cmd.fib_shrink = sts.n_lt_cur;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
			end
			ST_COMPARE: begin
				if (mode_two) begin
					cmd.upd_two = 1'b1;
				end else begin
					cmd.upd_three  = !sts.eq;
					cmd.finish     = sts.eq || !sts.nxt_nonempty;
					cmd.finish_hit = sts.eq;
				end
			end
			ST_LAST_READ: begin
				cmd.last_rd = 1'b1;
			end
			ST_LAST_CMP: begin
				cmd.finish     = 1'b1;
				cmd.finish_hit = sts.eq;
				cmd.rank_lo    = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = state_q != ST_IDLE;

	`STS_ASSERT_NXT(a_finish_to_idle, cmd.finish, state_q == ST_IDLE, "search finished but still busy")

endmodule

>>> hw/rtl/sorted_table_search.sv
// Top level of the sorted table search: register port, controller and datapath.
//
// Usage: the block holds a table of TABLE_DEPTH signed words kept in ascending order.
// A transaction is taken on a rising edge with start high and busy low. Command load
// writes item_value at entry_index (positions at or above TABLE_DEPTH are dropped) and
// gives no result. Command search looks for item_value in ranks [range_low, range_high)
// and gives one result: done is high for exactly one cycle with found and match_rank.
// The search_mode register (APB, address 0) selects three-way binary, Fibonacci or
// two-way binary (last equal entry) search; write it only while the block is idle.
// Sequencing: a load does not make the block busy. A search with an empty range raises
// done in the cycle after it is taken. Otherwise each probe is a memory read, then a
// compare, since the single registered read port of the table serializes the probes.
// Two-way binary ends with a final read and compare of the lowest remaining entry;
// Fibonacci first steps up the sequence, then steps down it before each probe. The next
// transaction may be taken in the cycle the result is shown.
// Reset clears the sequencer and search_mode to zero; table contents are undefined until
// written. The receiver cannot stall: each result is shown for one cycle only.
module sorted_table_search import sts_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic                          command,
	input  logic [INDEX_W-1:0]            entry_index,
	input  logic signed [VALUE_WIDTH-1:0] item_value,
	input  logic [RANGE_W-1:0]            range_low,
	input  logic [RANGE_W-1:0]            range_high,
	output logic                          done,
	output logic                          found,
	output logic [RANK_W-1:0]             match_rank,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [PADDR_W-1:0]            paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic [1:0]  mode_q;
	logic        mode_we;
	sts_cmd_t    cmd;
	sts_status_t sts;

	// Register write decode
	assign pready  = 1'b1;
	assign mode_we = psel && penable && pwrite && pready && (paddr == ADDR_SEARCH_MODE);

	// Mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_THREE_WAY;
		end else if (mode_we) begin
			mode_q <= pwdata[1:0];
		end
	end

	// Register read-back
	always_comb begin
		prdata = '0;
		if (paddr == ADDR_SEARCH_MODE) begin
			prdata = {30'd0, mode_q};
		end
	end

	sts_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.command     (command),
		.search_mode (mode_q),
		.sts         (sts),
		.cmd         (cmd),
		.busy        (busy)
	);

	sts_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.entry_index (entry_index),
		.item_value  (item_value),
		.range_low   (range_low),
		.range_high  (range_high),
		.sts         (sts),
		.done        (done),
		.found       (found),
		.match_rank  (match_rank)
	);

endmodule

>>> test/sorted_table_search_checker.sv
// Predicts search answers from observed transactions and compares them with the block's results.
`timescale 1ns / 100ps

module sorted_table_search_checker import sts_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic                     busy,
	input  logic                     command,
	input  logic [INDEX_W-1:0]       entry_index,
	input  logic signed [31:0]       item_value,
	input  logic [RANGE_W-1:0]       range_low,
	input  logic [RANGE_W-1:0]       range_high,
	input  logic                     done,
	input  logic                     found,
	input  logic [RANK_W-1:0]        match_rank,
	input  logic                     psel,
	input  logic                     penable,
	input  logic                     pwrite,
	input  logic [PADDR_W-1:0]       paddr,
	input  logic [31:0]              pwdata,
	input  logic                     pready,
	output int                       mismatch_count,
	output int                       outstanding
);

	localparam int DEPTH   = 1024;
	localparam int NO_HIT  = -1;

	typedef struct packed {
		logic              found;
		logic [RANK_W-1:0] rank;
	} answer_t;

	logic signed [31:0] entries [0:DEPTH-1];
	logic [1:0]         mode_copy;
	answer_t            pending_answers[$];
	int                 errs;

	// Walk the probes of the selected scheme over [lo, hi); give the rank hit or NO_HIT
	function automatic int locate_key(logic [1:0] mode, logic signed [31:0] key, int lo, int hi);
		int mi;
		int t;
		int prev;
		int cur;
		case (mode)
			MODE_FIBONACCI: begin
				prev = 1;
				cur  = 0;
				while (cur < hi - lo) begin
					t    = cur + prev;
					prev = cur;
					cur  = t;
				end
				while (lo < hi) begin
					while (hi - lo < cur) begin
						t    = cur - prev;
						cur  = prev;
						prev = t;
					end
					mi = lo + cur - 1;
					if (key < entries[mi]) hi = mi;
					else if (entries[mi] < key) lo = mi + 1;
					else return mi;
				end
			end
			MODE_TWO_WAY: begin
				while (hi - lo > 1) begin
					mi = (lo + hi) >> 1;
					if (key < entries[mi]) hi = mi;
					else lo = mi;
				end
				if (entries[lo] == key) return lo;
			end
			default: begin
				while (lo < hi) begin
					mi = (lo + hi) >> 1;
					if (key < entries[mi]) hi = mi;
					else if (entries[mi] < key) lo = mi + 1;
					else return mi;
				end
			end
		endcase
		return NO_HIT;
	endfunction

	// Track register writes and transactions, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin : watch
		answer_t want;
		answer_t got;
		int      hi_sat;
		int      rank_v;
		if (!arst_n) begin
			mode_copy = MODE_THREE_WAY;
			pending_answers.delete();
			errs = 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == ADDR_SEARCH_MODE)
				mode_copy = pwdata[1:0];

			if (start && !busy) begin
				if (command == CMD_LOAD) begin
					entries[entry_index] = item_value;
				end else begin
					hi_sat = (range_high > DEPTH) ? DEPTH : int'(range_high);
					rank_v = (int'(range_low) < hi_sat) ?
						locate_key(mode_copy, item_value, int'(range_low), hi_sat) : NO_HIT;
					want.found = (rank_v != NO_HIT);
					want.rank  = want.found ? rank_v[RANK_W-1:0] : '0;
					pending_answers.push_back(want);
				end
			end

			if (done) begin
				got.found = found;
				got.rank  = match_rank;
				if (pending_answers.size() == 0) begin
					if (errs < 10)
						$display("%0t: result with no search pending: found=%0d rank=%0d",
							$realtime, got.found, got.rank);
					errs++;
				end else begin
					want = pending_answers.pop_front();
					if (got.found !== want.found || got.rank !== want.rank) begin
						if (errs < 10)
							$display("%0t: mismatch: expected found=%0d rank=%0d, got found=%0d rank=%0d",
								$realtime, want.found, want.rank, got.found, got.rank);
						errs++;
					end
				end
			end
		end
		mismatch_count <= errs;
		outstanding    <= pending_answers.size();
	end

endmodule

>>> test/tb_sorted_table_search.sv
// Stimulus, clocking and verdict for the sorted table search block.
`timescale 1ns / 100ps

module tb_sorted_table_search;
	import sts_pkg::*;

	localparam int                 DEPTH          = 1024;
	localparam int                 ITEM_TARGET    = 900;
	localparam int                 WATCHDOG_LIMIT = 4000;
	localparam logic signed [31:0] VAL_MIN        = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX        = 32'sh7FFF_FFFF;

	logic                 clk         = 1'b0;
	logic                 arst_n      = 1'b0;
	logic                 start       = 1'b0;
	logic                 busy;
	logic                 command     = CMD_LOAD;
	logic [INDEX_W-1:0]   entry_index = '0;
	logic signed [31:0]   item_value  = '0;
	logic [RANGE_W-1:0]   range_low   = '0;
	logic [RANGE_W-1:0]   range_high  = '0;
	logic                 done;
	logic                 found;
	logic [RANK_W-1:0]    match_rank;
	logic                 psel        = 1'b0;
	logic                 penable     = 1'b0;
	logic                 pwrite      = 1'b0;
	logic [PADDR_W-1:0]   paddr       = '0;
	logic [31:0]          pwdata      = '0;
	logic [31:0]          prdata;
	logic                 pready;

	int mismatch_count;
	int outstanding;
	int quiet_cycles = 0;
	int burst_left   = 0;
	int items_sent   = 0;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	sorted_table_search DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .entry_index(entry_index), .item_value(item_value),
		.range_low(range_low), .range_high(range_high),
		.done(done), .found(found), .match_rank(match_rank),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	sorted_table_search_checker u_answer_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .entry_index(entry_index), .item_value(item_value),
		.range_low(range_low), .range_high(range_high),
		.done(done), .found(found), .match_rank(match_rank),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .pready(pready),
		.mismatch_count(mismatch_count), .outstanding(outstanding)
	);

	// End the run when nothing has moved for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable && pwrite && pready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one transaction and hold it until the block takes it; gap between bursts
	task automatic issue_op(input logic cmd, input int idx, input logic signed [31:0] val,
			input int lo, input int hi);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		start       <= 1'b1;
		command     <= cmd;
		entry_index <= idx[INDEX_W-1:0];
		item_value  <= val;
		range_low   <= lo[RANGE_W-1:0];
		range_high  <= hi[RANGE_W-1:0];
		do @(posedge clk); while (busy);
		items_sent++;
	endtask

	// Drop start and wait until every answer is in and the block is quiet
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write search_mode over the register port, with random upper data bits at times
	task automatic set_mode(input logic [1:0] m);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_SEARCH_MODE;
		pwdata  <= ($urandom_range(0, 1) ? ($urandom() & 32'hFFFF_FFFC) : 32'h0) | {30'd0, m};
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	initial begin
		int                 n;
		int                 base;
		int                 lo;
		int                 hi;
		int                 hi_eff;
		int                 k;
		int                 searches;
		int                 phase;
		int                 center;
		int                 style;
		logic signed [31:0] key;
		logic signed [31:0] seg[$];

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes at both ends of the table and duplicates near its start
		issue_op(CMD_LOAD, 0, VAL_MIN, 0, 0);
		issue_op(CMD_LOAD, 1, VAL_MIN + 1, 2047, 2047);
		issue_op(CMD_LOAD, 2, -1, 0, 0);
		issue_op(CMD_LOAD, 3, 0, 0, 0);
		issue_op(CMD_LOAD, 4, 0, 0, 0);
		issue_op(CMD_LOAD, 5, VAL_MAX, 0, 0);
		issue_op(CMD_LOAD, 1022, 100, 0, 0);
		issue_op(CMD_LOAD, 1023, VAL_MAX, 0, 0);
		// Every mode including the unused code, saturated end and empty ranges
		for (int m = 0; m < 4; m++) begin
			set_mode(m[1:0]);
			issue_op(CMD_SEARCH, 0, 0, 0, 6);
			issue_op(CMD_SEARCH, 1023, VAL_MIN, 0, 6);
			issue_op(CMD_SEARCH, 0, VAL_MAX, 1022, 2047);
			case (m)
				0: issue_op(CMD_SEARCH, 0, 0, 3, 3);
				1: issue_op(CMD_SEARCH, 0, 7, 0, 6);
				2: issue_op(CMD_SEARCH, 0, VAL_MAX, 1024, 2047);
				default: issue_op(CMD_SEARCH, 0, -5, 1, 5);
			endcase
		end

		// Random: load a sorted segment, then search inside it
		phase = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase == 0 || $urandom_range(0, 2) == 0)
				set_mode(2'($urandom_range(0, 3)));

			if (phase == 3) n = 256;
			else if ($urandom_range(0, 9) < 8) n = $urandom_range(1, 16);
			else n = $urandom_range(17, 64);
			base = ($urandom_range(0, 7) == 0 || phase == 3) ? DEPTH - n :
				$urandom_range(0, DEPTH - n);

			// Build values: wide spread, tight cluster with repeats, or extremes
			seg.delete();
			style  = $urandom_range(0, 2);
			center = $signed($urandom()) >>> 1;
			for (k = 0; k < n; k++) begin
				case (style)
					0: seg.push_back($signed($urandom()));
					1: seg.push_back(center + $urandom_range(0, 7));
					default: case ($urandom_range(0, 4))
						0: seg.push_back(VAL_MIN);
						1: seg.push_back(VAL_MIN + 1);
						2: seg.push_back(0);
						3: seg.push_back(VAL_MAX - 1);
						default: seg.push_back(VAL_MAX);
					endcase
				endcase
			end
			// Leave a few segments unsorted
			if ($urandom_range(0, 9) != 0) seg.sort();
			for (k = 0; k < n; k++)
				issue_op(CMD_LOAD, base + k, seg[k], $urandom_range(0, 2047),
					$urandom_range(0, 2047));

			searches = $urandom_range(4, 16);
			for (int s = 0; s < searches; s++) begin
				if ($urandom_range(0, 5) == 0) begin
					lo = base;
					hi = base + n;
				end else begin
					lo = $urandom_range(base, base + n);
					hi = $urandom_range(lo, base + n);
				end
				if (base + n == DEPTH && $urandom_range(0, 1) == 0)
					hi = $urandom_range(DEPTH, 2047);
				hi_eff = (hi > DEPTH) ? DEPTH : hi;
				case ($urandom_range(0, 5))
					0, 1, 2: key = (lo < hi_eff) ?
						seg[$urandom_range(lo - base, hi_eff - 1 - base)] : $signed($urandom());
					3: key = seg[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 1 : -1);
					4: key = $signed($urandom());
					default: key = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
				endcase
				issue_op(CMD_SEARCH, $urandom_range(0, DEPTH - 1), key, lo, hi);

				// Noise: empty ranges with random fields, stray overwrites in the segment
				if ($urandom_range(0, 4) == 0) begin
					hi = $urandom_range(0, 2047);
					lo = $urandom_range((hi > DEPTH) ? DEPTH : hi, 2047);
					issue_op(CMD_SEARCH, $urandom_range(0, DEPTH - 1), $signed($urandom()), lo, hi);
				end
				if ($urandom_range(0, 9) == 0) begin
					k = $urandom_range(0, n - 1);
					seg[k] = $signed($urandom());
					issue_op(CMD_LOAD, base + k, seg[k], $urandom_range(0, 2047),
						$urandom_range(0, 2047));
				end
			end
			phase++;
		end

		// Drain outstanding answers, then watch for stray results
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (64) @(posedge clk);
		if (mismatch_count == 0 && outstanding == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
